// ===== sv/tri_inc_pkg.sv =====
// Shared types for the triangle incenter pipeline.
`default_nettype none

package tri_inc_pkg;

  // One-bit status flag carried on the result channel.
  typedef logic flag_t;

endpackage

`default_nettype wire

// ===== sv/tri_inc_if.sv =====
// Valid/ready channel interfaces for triangle items and incenter results.
`default_nettype none

interface tri_inc_in_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tri_inc_out_if import tri_inc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ix;
  logic signed [COORD_WIDTH-1:0] iy;
  flag_t                         degenerate;

  modport source (output valid, ix, iy, degenerate, input ready);
  modport sink   (input valid, ix, iy, degenerate, output ready);
endinterface

`default_nettype wire

// ===== sv/triangle_incenter.sv =====
// Triangle incenter: side-length weighted vertex average in signed fixed point.
`default_nettype none

// Takes one triangle (three vertices, signed fixed point, COORD_WIDTH bits
// each) per item and returns the incenter in the same format. Each vertex is
// weighted by the truncated integer square root of the squared length of the
// opposite side; the weighted sums are divided by the sum of the lengths and
// truncated toward zero. The fixed-point position is irrelevant to the logic:
// the same bits come out for any number of fraction bits. If all three
// vertices coincide the total length is zero; the result is then 0,0 with
// degenerate set. Throughput is one item per clock unless the output is held.
// The square root settles one root bit per stage (COORD_WIDTH+1 stages) and
// the divider one quotient bit per stage (COORD_WIDTH stages). The pipeline
// advances as one; it halts only while a finished result sits unread in the
// output register.
module triangle_incenter import tri_inc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tri_inc_in_if.sink    in_i,
  tri_inc_out_if.source res_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;       // |coordinate difference|
  localparam int unsigned SW = 2 * W + 3;   // squared distance
  localparam int unsigned LW = W + 1;       // side length
  localparam int unsigned TW = W + 3;       // total length
  localparam int unsigned PW = 2 * W + 2;   // weighted coordinate
  localparam int unsigned NW = PW + 2;      // sum of three weighted terms

  // Global advance: the whole pipe moves unless the output is held.
  logic en;
  logic out_v_q;

  assign en         = !out_v_q || res_o.ready;
  assign in_i.ready = en;

  // ---------------------------------------------------------------------
  // Stage 1: side differences as magnitudes. Side k lies opposite vertex k.
  // ---------------------------------------------------------------------
  logic signed [W-1:0] in_x [3];
  logic signed [W-1:0] in_y [3];

  assign in_x[0] = in_i.ax;
  assign in_y[0] = in_i.ay;
  assign in_x[1] = in_i.bx;
  assign in_y[1] = in_i.by_coord;
  assign in_x[2] = in_i.cx;
  assign in_y[2] = in_i.cy;

  logic            s1_v_q;
  logic [DW-1:0]   s1_dx_q [3];
  logic [DW-1:0]   s1_dy_q [3];
  logic [6*W-1:0]  s1_c_q;

  logic [DW-1:0]   s1_dx_d [3];
  logic [DW-1:0]   s1_dy_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_diff
    localparam int unsigned PA = (k + 1) % 3;
    localparam int unsigned PB = (k + 2) % 3;
    logic signed [W:0] dxs;
    logic signed [W:0] dys;
    always_comb begin
      dxs = {in_x[PB][W-1], in_x[PB]} - {in_x[PA][W-1], in_x[PA]};
      dys = {in_y[PB][W-1], in_y[PB]} - {in_y[PA][W-1], in_y[PA]};
      s1_dx_d[k] = dxs[W] ? DW'(-dxs) : DW'(dxs);
      s1_dy_d[k] = dys[W] ? DW'(-dys) : DW'(dys);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q <= s1_dx_d;
      s1_dy_q <= s1_dy_d;
      s1_c_q  <= {in_i.cy, in_i.cx, in_i.by_coord, in_i.bx, in_i.ay, in_i.ax};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2 and root stages. Index 0 holds the squared distance; each
  // following stage settles one root bit, MSB first.
  // ---------------------------------------------------------------------
  logic            rt_v_q    [LW+1];
  logic [SW-1:0]   rt_rem_q  [LW+1][3];
  logic [LW-1:0]   rt_root_q [LW+1][3];
  logic [6*W-1:0]  rt_c_q    [LW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q[0] <= 1'b0;
    end else if (en) begin
      rt_v_q[0] <= s1_v_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_rem_q[0][k]  <= SW'(s1_dx_q[k] * s1_dx_q[k]) + SW'(s1_dy_q[k] * s1_dy_q[k]);
        rt_root_q[0][k] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_c_q[0] <= s1_c_q;
    end
  end

  for (genvar j = 0; j < LW; j++) begin : g_root
    localparam int unsigned B = LW - 1 - j;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[j+1] <= 1'b0;
      end else if (en) begin
        rt_v_q[j+1] <= rt_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_c_q[j+1] <= rt_c_q[j];
      end
    end
    for (genvar k = 0; k < 3; k++) begin : g_side
      logic [SW-1:0] trial;
      logic [SW-1:0] rem_d;
      logic [LW-1:0] root_d;
      always_comb begin
        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        trial  = (SW'(rt_root_q[j][k]) << (B + 1)) + (SW'(1) << (2 * B));
        rem_d  = rt_rem_q[j][k];
        root_d = rt_root_q[j][k];
        if (rt_rem_q[j][k] >= trial) begin
          rem_d  = rt_rem_q[j][k] - trial;
          root_d = rt_root_q[j][k] | (LW'(1) << B);
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          rt_rem_q[j+1][k]  <= rem_d;
          rt_root_q[j+1][k] <= root_d;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Weighting: each vertex times the length of its opposite side.
  // ---------------------------------------------------------------------
  logic                 wt_v_q;
  logic [LW-1:0]        wt_len_q [3];
  logic signed [PW-1:0] wt_p_q   [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_v_q <= 1'b0;
    end else if (en) begin
      wt_v_q <= rt_v_q[LW];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_wt
    logic signed [LW:0]  len_s;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    always_comb begin
      len_s = $signed({1'b0, rt_root_q[LW][k]});
      vx    = $signed(rt_c_q[LW][W*(2*k) +: W]);
      vy    = $signed(rt_c_q[LW][W*(2*k+1) +: W]);
      px    = len_s * vx;
      py    = len_s * vy;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        wt_len_q[k]  <= rt_root_q[LW][k];
        wt_p_q[0][k] <= px;
        wt_p_q[1][k] <= py;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sums of weighted coordinates and of lengths.
  // ---------------------------------------------------------------------
  logic                 sm_v_q;
  logic signed [NW-1:0] sm_s_q [2];
  logic [TW-1:0]        sm_tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_v_q <= 1'b0;
    end else if (en) begin
      sm_v_q <= wt_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        sm_s_q[a] <= NW'(wt_p_q[a][0]) + NW'(wt_p_q[a][1]) + NW'(wt_p_q[a][2]);
      end
      sm_tot_q <= TW'(wt_len_q[0]) + TW'(wt_len_q[1]) + TW'(wt_len_q[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Divider: sign split at index 0, then one quotient bit per stage.
  // The quotient never exceeds W bits, so the top of the magnitude seeds
  // the remainder directly and the low W bits shift through acc.
  // ---------------------------------------------------------------------
  logic          dv_v_q   [W+1];
  logic          dv_dg_q  [W+1];
  logic [TW-1:0] dv_den_q [W+1];
  logic          dv_neg_q [W+1][2];
  logic [TW-1:0] dv_rem_q [W+1][2];
  logic [W-1:0]  dv_acc_q [W+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sm_v_q;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_prep
    logic [NW-1:0] mag;
    always_comb begin
      mag = sm_s_q[a][NW-1] ? NW'(-sm_s_q[a]) : NW'(sm_s_q[a]);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_neg_q[0][a] <= sm_s_q[a][NW-1];
        // magnitude stays below total * 2^W, so its top bit is always clear
        dv_rem_q[0][a] <= mag[W+TW-1:W];
        dv_acc_q[0][a] <= mag[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_dg_q[0]  <= (sm_tot_q == '0);
      dv_den_q[0] <= sm_tot_q;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_dg_q[j+1]  <= dv_dg_q[j];
        dv_den_q[j+1] <= dv_den_q[j];
      end
    end
    for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [TW:0]   t;
      logic [TW-1:0] rem_d;
      logic          qbit;
      always_comb begin
        t     = {dv_rem_q[j][a], dv_acc_q[j][a][W-1]};
        qbit  = (t >= {1'b0, dv_den_q[j]});
        rem_d = qbit ? TW'(t - {1'b0, dv_den_q[j]}) : t[TW-1:0];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_neg_q[j+1][a] <= dv_neg_q[j][a];
          dv_rem_q[j+1][a] <= rem_d;
          dv_acc_q[j+1][a] <= {dv_acc_q[j][a][W-2:0], qbit};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: restore sign, force zero on a degenerate triangle.
  // ---------------------------------------------------------------------
  logic signed [W-1:0] out_ix_q;
  logic signed [W-1:0] out_iy_q;
  flag_t               out_dg_q;
  logic [W-1:0]        res_d [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (dv_dg_q[W]) begin
        res_d[a] = '0;
      end else if (dv_neg_q[W][a]) begin
        res_d[a] = -dv_acc_q[W][a];
      end else begin
        res_d[a] = dv_acc_q[W][a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ix_q <= $signed(res_d[0]);
      out_iy_q <= $signed(res_d[1]);
      out_dg_q <= dv_dg_q[W];
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.ix         = out_ix_q;
  assign res_o.iy         = out_iy_q;
  assign res_o.degenerate = out_dg_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Zero total length means coincident vertices, so weighted sums vanish.
  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_v_q && (sm_tot_q == '0) |-> (sm_s_q[0] == '0) && (sm_s_q[1] == '0))
    else $error("zero total with nonzero weighted sum");

  // The divider remainder ends below the divisor on real triangles.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[W] && !dv_dg_q[W] |->
      (dv_rem_q[W][0] < dv_den_q[W]) && (dv_rem_q[W][1] < dv_den_q[W]))
    else $error("divider remainder out of range");

  // A held output freezes the whole pipe: no item lost or duplicated.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_v_q) && $stable(rt_v_q[LW]) && $stable(dv_v_q[W]))
    else $error("pipeline moved during stall");

  // An accepted item occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_v_q)
    else $error("accepted item missing from first stage");

endmodule

`default_nettype wire
